[rtl/hwd_pkg.sv]
// Shared types, constants and helper functions for the Hamming weight
// distribution unit. No dependencies; every other file imports this package.
package hwd_pkg;

  localparam int DEF_MAX_DATA_BITS = 40;
  localparam int DEF_HIST_ENTRIES  = 48;
  localparam int MIN_DATA_BITS     = 8;

  localparam int DATA_BITS_W = 6;
  localparam int WEIGHT_W    = 6;
  localparam int CNT_W       = 41;
  localparam int COUNT_W     = 64;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int PAR_MAX     = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DATA_BITS_W-1:0] DEF_DATA_BITS      = DATA_BITS_W'(MIN_DATA_BITS);
  localparam logic [WEIGHT_W-1:0]    MIN_COUNTED_WEIGHT = WEIGHT_W'(2);
  localparam logic [WEIGHT_W-1:0]    FIRST_SHIFTED_BIN  = WEIGHT_W'(3);

  // Parity selection masks, one per parity bit.
  localparam logic [63:0] PAR_MASK [PAR_MAX] = '{
    64'h0000_0000_56AA_AD5B,
    64'h0000_0000_9B33_366D,
    64'h0000_0000_E3C3_C78E,
    64'h0000_0000_03FC_07F0,
    64'h0000_0000_03FF_F800,
    64'h0000_0000_FC00_0000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_BITS   = 4'd0,
    REG_SPHERE_MODE = 4'd1
  } cfg_reg_t;

  // Working mode derived from the configuration registers.
  typedef struct packed {
    logic [WEIGHT_W-1:0] n;        // data width in use
    logic [WEIGHT_W-1:0] nh;       // data width plus Hamming parity bits
    logic [WEIGHT_W-1:0] bin_cnt;  // number of bins emitted on finish
    logic [2:0]          par_cnt;  // parity bits of the codeword
    logic                sphere;
  } cfg_t;

  typedef struct packed {
    logic                fin;
    logic [WEIGHT_W-1:0] weight;
  } q_item_t;

  typedef enum logic [2:0] {
    BK_RUN,
    BK_FREAD,
    BK_FSHIFT,
    BK_FCALC,
    BK_FEMIT
  } back_state_t;

  function automatic cfg_t derive_cfg(input logic [DATA_BITS_W-1:0] data_bits,
                                      input logic sphere, input int max_bits,
                                      input int hist_entries);
    cfg_t c;
    int   n;
    int   h;
    int   b;
    n = int'(data_bits);
    if (n < MIN_DATA_BITS) n = MIN_DATA_BITS;
    if (n > max_bits) n = max_bits;
    h = (n == 8) ? 5 : ((n < 32) ? 6 : 7);
    b = n + h + 1;
    if (b > hist_entries) b = hist_entries;
    c.n       = WEIGHT_W'(n);
    c.nh      = WEIGHT_W'(n + h);
    c.bin_cnt = WEIGHT_W'(b);
    c.par_cnt = 3'((n < 16) ? 4 : ((n < 32) ? 5 : 6));
    c.sphere  = sphere;
    return c;
  endfunction

  function automatic logic [3:0] byte_ones(input logic [7:0] v);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 4'(v[i]);
    end
    return s;
  endfunction

endpackage

[rtl/hwd_ifs.sv]
// Channel interfaces of the Hamming weight distribution unit: item input,
// bin output and configuration write. Depends on hwd_pkg.
interface hwd_in_if import hwd_pkg::*; #(parameter int DATA_W = DEF_MAX_DATA_BITS) ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [DATA_W-1:0] data_word;
  modport source (output valid, op, data_word, input ready);
  modport sink   (input valid, op, data_word, output ready);
endinterface

interface hwd_out_if import hwd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic [COUNT_W-1:0]  count_low;
  logic [COUNT_W-1:0]  count_high;
  logic                last;
  modport source (output valid, weight, count_low, count_high, last, input ready);
  modport sink   (input valid, weight, count_low, count_high, last, output ready);
endinterface

interface hwd_cfg_if import hwd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/hamming_weight_distribution_unit.sv]
// Top level of the Hamming weight distribution unit: configuration registers,
// front end, item queue and back end. Depends on hwd_pkg, hwd_ifs and submodules.
//
//   channel  dir  beat contents                                  handshake
//   cfg      in   index, data (register write)                   valid/ready
//   item     in   op, data_word                                  valid/ready
//   result   out  weight, count_low, count_high, last            valid/ready
//
// Accumulate beats are taken one per cycle unless the queue is full; a word
// reaches its histogram bin through the front register, the queue and the memory read.
// A finish steps each bin through read, shift, calculate and emit, using the histogram's
// single read port; items keep entering the queue until it holds four.
// Reset clears the histogram valid bits at once, with no clearing pass.
// A bin held in the output register waits for ready; the sequencer waits with it.
module hamming_weight_distribution_unit import hwd_pkg::*; #(
  parameter int MAX_DATA_BITS = DEF_MAX_DATA_BITS,
  parameter int HIST_ENTRIES  = DEF_HIST_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  hwd_cfg_if.sink   cfg,
  hwd_in_if.sink    item,
  hwd_out_if.source result
);

  logic [DATA_BITS_W-1:0] data_bits;
  logic                   sphere_mode;
  cfg_t                   mode;

  logic    push;
  q_item_t push_item;
  logic    full;
  logic    pop;
  q_item_t pop_item;
  logic    q_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits   <= DEF_DATA_BITS;
      sphere_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_DATA_BITS:   data_bits   <= cfg.data[DATA_BITS_W-1:0];
        REG_SPHERE_MODE: sphere_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign mode = derive_cfg(data_bits, sphere_mode, MAX_DATA_BITS, HIST_ENTRIES);

  hwd_front #(
    .DATA_W (MAX_DATA_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .item      (item),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  hwd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .valid     (q_valid)
  );

  hwd_back #(
    .HIST_ENTRIES (HIST_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .mode    (mode),
    .q_valid (q_valid),
    .q_item  (pop_item),
    .pop     (pop),
    .result  (result)
  );

endmodule

[rtl/hwd_front.sv]
// Front end: accepts items, encodes accumulate words and computes the
// codeword weight. Depends on hwd_pkg and hwd_ifs.
module hwd_front import hwd_pkg::*; #(
  parameter int DATA_W = DEF_MAX_DATA_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    mode,
  hwd_in_if.sink  item,
  output logic    push,
  output q_item_t push_item,
  input  logic    full
);

  localparam int NCHUNK = (DATA_W + 7) / 8;
  localparam int PAD_W  = NCHUNK * 8;

  logic              accept;
  logic [DATA_W-1:0] dmask;
  logic [DATA_W-1:0] v;
  logic [PAR_MAX-1:0] par;
  logic [PAD_W-1:0]  vpad;
  logic [3:0]        cnt_c [NCHUNK];
  logic [2:0]        pcnt_c;
  logic [WEIGHT_W-1:0] wsum;

  logic       f1_valid;
  logic       f1_fin;
  logic [3:0] f1_cnt [NCHUNK];
  logic [2:0] f1_pcnt;

  assign item.ready = !f1_valid || !full;
  assign accept     = item.valid && item.ready;
  assign push       = f1_valid && !full;

  // Mask to the width in use, form the parity bits and count ones per byte.
  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      dmask[i] = (i < int'(mode.n));
    end
    v = item.data_word[DATA_W-1:0] & dmask;
    for (int j = 0; j < PAR_MAX; j++) begin
      par[j] = (^(v & PAR_MASK[j][DATA_W-1:0])) && (j < int'(mode.par_cnt));
    end
    vpad = PAD_W'(v);
    for (int k = 0; k < NCHUNK; k++) begin
      cnt_c[k] = byte_ones(vpad[8*k +: 8]);
    end
    pcnt_c = '0;
    for (int j = 0; j < PAR_MAX; j++) begin
      pcnt_c = pcnt_c + 3'(par[j]);
    end
  end

  always_comb begin
    wsum = WEIGHT_W'(f1_pcnt);
    for (int k = 0; k < NCHUNK; k++) begin
      wsum = wsum + WEIGHT_W'(f1_cnt[k]);
    end
    push_item.fin    = f1_fin;
    push_item.weight = wsum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (push) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_fin  <= item.op;
      f1_cnt  <= cnt_c;
      f1_pcnt <= pcnt_c;
    end
  end

endmodule

[rtl/hwd_queue.sv]
// Short queue of classified items between the front and back ends.
// Depends on hwd_pkg.
module hwd_queue import hwd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output q_item_t pop_item,
  output logic    valid
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  q_item_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full     = (count == CNT_QW'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) begin
        count <= count + CNT_QW'(1);
      end else if (pop && !push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

[rtl/hwd_back.sv]
// Back end: histogram memory with read-modify-write per accumulate beat and
// the finish sequencer that folds and emits the bins. Depends on hwd_pkg, hwd_ifs.
module hwd_back import hwd_pkg::*; #(
  parameter int HIST_ENTRIES = DEF_HIST_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      mode,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      pop,
  hwd_out_if.source result
);

  localparam int ADDR_W = $clog2(HIST_ENTRIES);
  localparam int E_W    = CNT_W + 1;
  localparam int PROD_W = E_W + WEIGHT_W;

  back_state_t state, state_next;

  logic [CNT_W-1:0]        hist_mem [HIST_ENTRIES];
  logic [HIST_ENTRIES-1:0] entry_valid;
  logic [ADDR_W-1:0]       rd_addr;
  logic [CNT_W-1:0]        rd_data;
  logic                    rd_vld;

  logic              a_count;
  logic              b_valid;
  logic [ADDR_W-1:0] b_addr;
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [CNT_W-1:0]  fwd_data;
  logic [CNT_W-1:0]  cur;
  logic [CNT_W-1:0]  wr_data;

  logic [WEIGHT_W-1:0] bin;
  logic [WEIGHT_W:0]   bin_up;
  logic [WEIGHT_W:0]   f_lo_full;
  logic [WEIGHT_W-1:0] f_lo;
  logic [WEIGHT_W-1:0] f_hi;
  logic                up_in_range;
  logic [CNT_W-1:0]    win [4];
  logic [E_W-1:0]      e_lo, e_hi, e_mid;
  logic [PROD_W-1:0]   prod_lo_c, prod_hi_c;
  logic [PROD_W-1:0]   prod_lo, prod_hi;
  logic [COUNT_W-1:0]  bin_val;
  logic [2*COUNT_W-1:0] wide;
  logic                load;
  logic                last_bin;
  logic                clear_all;

  logic                out_valid;
  logic [WEIGHT_W-1:0] out_weight;
  logic [COUNT_W-1:0]  out_low;
  logic [COUNT_W-1:0]  out_high;
  logic                out_last;

  assign result.valid      = out_valid;
  assign result.weight     = out_weight;
  assign result.count_low  = out_low;
  assign result.count_high = out_high;
  assign result.last       = out_last;

  // Classification of the queue head and histogram addressing.
  always_comb begin
    pop         = q_valid && (state == BK_RUN);
    a_count     = pop && !q_item.fin && (q_item.weight >= MIN_COUNTED_WEIGHT) &&
                  (q_item.weight < mode.bin_cnt);
    bin_up      = {1'b0, bin} + (WEIGHT_W+1)'(1);
    up_in_range = bin_up < {1'b0, mode.bin_cnt};
    last_bin    = (bin_up == {1'b0, mode.bin_cnt});
    if (state == BK_FREAD) begin
      rd_addr = up_in_range ? bin_up[ADDR_W-1:0] : '0;
    end else begin
      rd_addr = a_count ? q_item.weight[ADDR_W-1:0] : '0;
    end
    // The write of the previous beat lands at the same edge that captures
    // this beat's read, so it has to be forwarded.
    if (fwd_valid && (fwd_addr == b_addr)) begin
      cur = fwd_data;
    end else begin
      cur = rd_vld ? rd_data : '0;
    end
    wr_data = cur + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    rd_data <= hist_mem[rd_addr];
    if (b_valid) hist_mem[b_addr] <= wr_data;
  end

  // An entry whose valid bit is clear reads as zero, so reset and finish
  // clear the whole histogram at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_vld      <= 1'b0;
      b_valid     <= 1'b0;
      fwd_valid   <= 1'b0;
    end else begin
      rd_vld    <= entry_valid[rd_addr];
      b_valid   <= a_count;
      fwd_valid <= b_valid;
      if (clear_all) begin
        entry_valid <= '0;
      end else if (b_valid) begin
        entry_valid[b_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_addr   <= rd_addr;
    fwd_addr <= b_addr;
    fwd_data <= wr_data;
  end

  // Finish datapath. The window holds entries bin+1 down to bin-2; even bins
  // carry the folded odd bin below them.
  always_comb begin
    e_lo      = E_W'(win[2]) + E_W'(win[3]);
    e_hi      = E_W'(win[0]) + E_W'(win[1]);
    e_mid     = E_W'(win[1]) + E_W'(win[2]);
    f_lo_full = {1'b0, mode.nh} + (WEIGHT_W+1)'(1) - {1'b0, bin};
    f_lo      = f_lo_full[WEIGHT_W-1:0];
    f_hi      = bin_up[WEIGHT_W-1:0];
    prod_lo_c = PROD_W'(f_lo) * PROD_W'(e_lo);
    prod_hi_c = PROD_W'(f_hi) * PROD_W'(e_hi);

    if (bin == '0) begin
      bin_val = COUNT_W'(1) << mode.n;
    end else if (bin == WEIGHT_W'(1)) begin
      bin_val = COUNT_W'(mode.nh) << mode.n;
    end else if (!bin[0]) begin
      bin_val = COUNT_W'(e_mid);
    end else if (mode.sphere) begin
      bin_val = COUNT_W'(prod_lo) + (up_in_range ? COUNT_W'(prod_hi) : '0);
    end else begin
      // An odd bin is folded away unless it is the top bin.
      bin_val = up_in_range ? '0 : COUNT_W'(win[1]);
    end

    if (bin >= FIRST_SHIFTED_BIN) begin
      wide = {{COUNT_W{1'b0}}, bin_val} << mode.n;
    end else begin
      wide = {{COUNT_W{1'b0}}, bin_val};
    end

    load      = (state == BK_FEMIT) && (!out_valid || result.ready);
    clear_all = load && last_bin;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_RUN: begin
        if (pop && q_item.fin) state_next = BK_FREAD;
      end
      BK_FREAD:  state_next = BK_FSHIFT;
      BK_FSHIFT: state_next = BK_FCALC;
      BK_FCALC:  state_next = BK_FEMIT;
      BK_FEMIT: begin
        if (load) state_next = last_bin ? BK_RUN : BK_FREAD;
      end
      default: state_next = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      bin       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && q_item.fin) begin
        bin <= '0;
      end else if (load && !last_bin) begin
        bin <= bin_up[WEIGHT_W-1:0];
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.fin) begin
      for (int i = 0; i < 4; i++) begin
        win[i] <= '0;
      end
    end else if (state == BK_FSHIFT) begin
      win[0] <= (up_in_range && rd_vld) ? rd_data : '0;
      win[1] <= win[0];
      win[2] <= win[1];
      win[3] <= win[2];
    end
    if (state == BK_FCALC) begin
      prod_lo <= prod_lo_c;
      prod_hi <= prod_hi_c;
    end
    if (load) begin
      out_weight <= bin;
      out_low    <= wide[COUNT_W-1:0];
      out_high   <= wide[2*COUNT_W-1:COUNT_W];
      out_last   <= last_bin;
    end
  end

`ifndef SYNTHESIS
  a_emit_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == BK_FEMIT)
    else $error("bin beat appeared outside the emit step");

  a_no_write_in_finish: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> $past(state) == BK_RUN)
    else $error("histogram update started during a finish sequence");

  a_hist_cleared: assert property (@(posedge clk) disable iff (rst)
    clear_all |=> entry_valid == '0)
    else $error("histogram not cleared after the last bin");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hamming_weight_distribution_unit: a built-in weight
// predictor, a bin checker and random handshake pressure. Depends on hwd_pkg and hwd_ifs.
module tb;
  import hwd_pkg::*;

  localparam logic OP_ACCUM  = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(REG_SPHERE_MODE) +
                                                      CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] LAST_REG_INDEX   = '1;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 30;
  localparam int PHASE_ITEMS   = 98;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  count_low;
    logic [COUNT_W-1:0]  count_high;
    logic                last;
  } bin_t;

  logic clk;
  logic rst;

  hwd_cfg_if cfg_ch ();
  hwd_in_if  item_ch ();
  hwd_out_if res_ch ();

  hamming_weight_distribution_unit dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  // Predictor state: its own copy of the registers and the weight histogram.
  logic [DATA_BITS_W-1:0] width_reg;
  logic                   sphere_reg;
  logic [CNT_W-1:0]       bin_tally [DEF_HIST_ENTRIES];
  bin_t                   pending_bins [$];

  int cycles;
  int hold_until;
  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int items_sent;
  int finishes_sent;
  int bins_checked;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bins outstanding", cycles,
               pending_bins.size());
      $display("hamming_weight_distribution_unit verification failed");
      $finish;
    end
  end

  function automatic void decode_width(output int n, output int h, output int n_bins);
    n = int'(width_reg);
    if (n < MIN_DATA_BITS) n = MIN_DATA_BITS;
    if (n > DEF_MAX_DATA_BITS) n = DEF_MAX_DATA_BITS;
    h = (n == 8) ? 5 : ((n < 32) ? 6 : 7);
    n_bins = (n + h + 1 > DEF_HIST_ENTRIES) ? DEF_HIST_ENTRIES : n + h + 1;
  endfunction

  // Encodes one word and bumps the bin of its codeword weight if that weight is counted.
  function automatic void tally_word(input logic [DEF_MAX_DATA_BITS-1:0] word);
    int n, h, n_bins, p, w;
    logic [63:0] v;
    decode_width(n, h, n_bins);
    p = (n < 16) ? 4 : ((n < 32) ? 5 : 6);
    v = 64'(word) & ((64'd1 << n) - 64'd1);
    w = $countones(v);
    for (int i = 0; i < p; i++) w += int'(^(v & PAR_MASK[i]));
    if (w >= int'(MIN_COUNTED_WEIGHT) && w < n_bins) bin_tally[w] = bin_tally[w] + CNT_W'(1);
  endfunction

  // Turns the histogram into the code's weight distribution and queues every bin.
  function automatic void emit_distribution();
    int n, h, n_bins;
    logic [63:0] wdist [DEF_HIST_ENTRIES];
    logic [63:0] t;
    bin_t entry;
    decode_width(n, h, n_bins);
    foreach (wdist[d]) wdist[d] = 64'(bin_tally[d]);
    wdist[0] = 64'd1 << n;
    wdist[1] = 64'(n + h) << n;
    // Odd weights from three up fold into the next even one; an odd last bin stays where it is.
    for (int d = 4; d < n_bins; d += 2) begin
      wdist[d] = wdist[d] + wdist[d-1];
      wdist[d-1] = '0;
    end
    if (sphere_reg) begin
      for (int d = 3; d < n_bins; d += 2) begin
        t = 64'(n + h - d + 1) * wdist[d-1];
        if (d < n + h && d + 1 < DEF_HIST_ENTRIES) t = t + 64'(d + 1) * wdist[d+1];
        wdist[d] = t;
      end
    end
    for (int d = 0; d < n_bins; d++) begin
      entry.weight = WEIGHT_W'(d);
      if (d >= int'(FIRST_SHIFTED_BIN)) begin
        entry.count_low  = wdist[d] << n;
        entry.count_high = wdist[d] >> (64 - n);
      end else begin
        entry.count_low  = wdist[d];
        entry.count_high = '0;
      end
      entry.last = (d == n_bins - 1);
      pending_bins.push_back(entry);
    end
    foreach (bin_tally[d]) bin_tally[d] = '0;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < MAX_REPORTS)
      $display("MISMATCH cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  // Result side: checks each accepted beat, then decides ready for the next edge.
  initial begin : result_side
    bin_t want;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (pending_bins.size() == 0) begin
          report_mismatch("unexpected bin, weight", 64'(res_ch.weight), '0);
        end else begin
          want = pending_bins.pop_front();
          if (res_ch.weight !== want.weight)
            report_mismatch("weight", 64'(res_ch.weight), 64'(want.weight));
          if (res_ch.count_low !== want.count_low)
            report_mismatch($sformatf("count_low of bin %0d", want.weight),
                            res_ch.count_low, want.count_low);
          if (res_ch.count_high !== want.count_high)
            report_mismatch($sformatf("count_high of bin %0d", want.weight),
                            res_ch.count_high, want.count_high);
          if (res_ch.last !== want.last)
            report_mismatch($sformatf("last of bin %0d", want.weight),
                            64'(res_ch.last), 64'(want.last));
          bins_checked++;
        end
      end
      if (rst || cycles < hold_until) res_ch.ready <= 1'b0;
      else res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic [DEF_MAX_DATA_BITS-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.op        <= op;
    item_ch.data_word <= word;
    do @(posedge clk); while (!item_ch.ready);
    if (op == OP_FINISH) begin
      emit_distribution();
      finishes_sent++;
    end else begin
      tally_word(word);
    end
    items_sent++;
  endtask

  // Lets every expected bin arrive, then gives queued accumulates time to land.
  task automatic wait_drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_bins.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_DATA_BITS) width_reg = val[DATA_BITS_W-1:0];
    else if (idx == REG_SPHERE_MODE) sphere_reg = val[0];
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [DEF_MAX_DATA_BITS-1:0] pick_word();
    case ($urandom_range(5))
      0: return '1;
      1, 2: return (40'd1 << $urandom_range(39)) | (40'd1 << $urandom_range(39));
      default: return DEF_MAX_DATA_BITS'({$urandom, $urandom});
    endcase
  endfunction

  task automatic reconfigure();
    logic [CFG_DATA_W-1:0] width_val;
    wait_drain();
    if ($urandom_range(9) < 7) width_val = CFG_DATA_W'(8 * $urandom_range(1, 5));
    else width_val = CFG_DATA_W'($urandom_range(255));
    write_reg(REG_DATA_BITS, width_val);
    write_reg(REG_SPHERE_MODE, CFG_DATA_W'($urandom_range(255)));
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX)),
                CFG_DATA_W'($urandom_range(255)));
  endtask

  task automatic test_reset_defaults();
    // Width 8 after reset: zero word, wide word with ignored upper bits, empty finish.
    send_item(OP_ACCUM, '0);
    send_item(OP_ACCUM, '1);
    send_item(OP_ACCUM, 40'h01);
    send_item(OP_ACCUM, 40'h80);
    send_item(OP_ACCUM, 40'hFF_0000_0100);
    send_item(OP_FINISH, '0);
    send_item(OP_FINISH, '1);
    wait_drain();
  endtask

  task automatic test_width_extremes();
    write_reg(REG_DATA_BITS, 8'd40);
    write_reg(REG_SPHERE_MODE, 8'd1);
    // Data bits above 31 sit in no parity mask, so this word has weight one.
    send_item(OP_ACCUM, 40'd1 << 35);
    send_item(OP_ACCUM, '1);
    send_item(OP_ACCUM, 40'h1);
    send_item(OP_FINISH, '0);
    wait_drain();
    write_reg(REG_DATA_BITS, 8'h07);
    write_reg(REG_SPHERE_MODE, 8'h00);
    send_item(OP_ACCUM, 40'hFF);
    send_item(OP_FINISH, '0);
    wait_drain();
    write_reg(REG_DATA_BITS, 8'hFF);
    write_reg(REG_SPHERE_MODE, 8'hFE);
    send_item(OP_ACCUM, pick_word());
    send_item(OP_FINISH, '0);
    wait_drain();
    write_reg(REG_DATA_BITS, 8'hE9);
    write_reg(REG_SPHERE_MODE, 8'h01);
    send_item(OP_ACCUM, 40'hFFFF);
    send_item(OP_ACCUM, 40'hFF_FFFF_0001);
    send_item(OP_FINISH, '0);
    wait_drain();
    write_reg(REG_DATA_BITS, 8'd16);
    write_reg(LAST_REG_INDEX, 8'hFF);
    write_reg(FIRST_UNUSED_REG, 8'h00);
    send_item(OP_ACCUM, 40'hA5C3);
    send_item(OP_FINISH, '0);
    wait_drain();
  endtask

  task automatic test_backpressure();
    wait_drain();
    write_reg(REG_DATA_BITS, 8'd40);
    write_reg(REG_SPHERE_MODE, 8'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Results blocked for a long stretch while items keep coming.
    hold_until = cycles + HOLD_CYCLES;
    send_item(OP_FINISH, '0);
    repeat (12) send_item(OP_ACCUM, pick_word());
    send_item(OP_FINISH, '0);
    wait_drain();
  endtask

  task automatic run_traffic(input int send_pct, input int stall_pct);
    int left, burst, r;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    reconfigure();
    left = PHASE_ITEMS;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 8) begin
        reconfigure();
      end else if (r < 80) begin
        burst = $urandom_range(1, 12);
        repeat (burst) send_item(OP_ACCUM, pick_word());
        send_item(OP_FINISH, DEF_MAX_DATA_BITS'({$urandom, $urandom}));
        left -= burst + 1;
      end else if (r < 90) begin
        send_item(OP_FINISH, DEF_MAX_DATA_BITS'({$urandom, $urandom}));
        left--;
      end else begin
        burst = $urandom_range(1, 4);
        repeat (burst) send_item(OP_ACCUM, pick_word());
        left -= burst;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(0, 0);
    run_traffic(53, 0);
    run_traffic(0, 53);
    run_traffic(32, 32);
  endtask

  initial begin
    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.op        <= OP_ACCUM;
    item_ch.data_word <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_DATA_BITS;
    cfg_ch.data       <= '0;
    width_reg  = DEF_DATA_BITS;
    sphere_reg = 1'b0;
    foreach (bin_tally[d]) bin_tally[d] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_width_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drain();
    if (pending_bins.size() != 0)
      report_mismatch("bins never delivered", 64'(pending_bins.size()), '0);

    $display("Sent %0d items with %0d finishes and %0d register writes; %0d bins compared.",
             items_sent, finishes_sent, reg_writes, bins_checked);
    $display("Widths 8 to 40 and beyond range, sphere counts on and off, with stalls.");
    if (errors == 0) begin
      $display("hamming_weight_distribution_unit verification clean");
    end else begin
      $display("hamming_weight_distribution_unit verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/hwd_pkg.sv
rtl/hwd_ifs.sv
rtl/hwd_front.sv
rtl/hwd_queue.sv
rtl/hwd_back.sv
rtl/hamming_weight_distribution_unit.sv
verif/tb.sv
